/* sv/min_heap_priority_queue_macros.svh */
// Assertion macros used by the heap queue checker.
`ifndef MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MHPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mhpq_pkg.sv */
// Shared constants and codes of the min-heap priority queue.
package mhpq_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int KEY_WIDTH_DEF = 32;

	// Capacity register
	localparam int              CAP_W     = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Configuration port
	localparam int   PADDR_W          = 3;
	localparam int   PDATA_W          = 32;
	localparam logic REG_IDX_CAPACITY = 1'b0;

	// Request commands
	localparam logic CMD_PUSH   = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

endpackage

/* sv/min_heap_priority_queue.sv */
// Top level of the min-heap priority queue: request control, heap RAM, result register.
// A rejected request, a push into an empty heap or a delete of the last slot goes straight
// to the result register; other requests climb or sink one level at a time. The one read port
// of the heap RAM sets the pace: one read per level up, two per level down.
// One request at a time; reset clears the count and sets capacity_limit to 64, RAM not cleared.
module min_heap_priority_queue #(
	parameter int DEPTH     = mhpq_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// Request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic signed [KEY_WIDTH-1:0]         key_in,
	input  logic [$clog2(DEPTH)-1:0]            position,

	// Result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic                                top_valid,
	output logic signed [KEY_WIDTH-1:0]         top_key,
	output logic [$clog2(DEPTH+1)-1:0]          count,

	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mhpq_pkg::PADDR_W-1:0]        paddr,
	input  logic [mhpq_pkg::PDATA_W-1:0]        pwdata,
	output logic [mhpq_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);

	localparam int AW   = $clog2(DEPTH);       // slot index
	localparam int CW   = $clog2(DEPTH + 1);   // entry count
	localparam int CHW  = AW + 2;              // child index, room for 2*slot+2
	localparam int CMPW = (CW > mhpq_pkg::CAP_W) ? CW : mhpq_pkg::CAP_W;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;   // wait for a request
	localparam logic [2:0] S_LAST = 3'd1;   // last entry arrives from RAM
	localparam logic [2:0] S_UP   = 3'd2;   // parent arrives, sift up one level
	localparam logic [2:0] S_DNL  = 3'd3;   // left child arrives
	localparam logic [2:0] S_DNR  = 3'd4;   // right child arrives, sink one level
	localparam logic [2:0] S_FIN  = 3'd5;   // drop the moving key into the hole
	localparam logic [2:0] S_DONE = 3'd6;   // hand the result to the output register

	function automatic logic key_lt(input logic [KEY_WIDTH-1:0] a,
	                                input logic [KEY_WIDTH-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] s);
		logic [AW-1:0] m;
		m = s - AW'(1);
		return m >> 1;
	endfunction

	function automatic logic [CHW-1:0] left_of(input logic [AW-1:0] s);
		return CHW'({s, 1'b1});
	endfunction

	function automatic logic [CHW-1:0] right_of(input logic [AW-1:0] s);
		return CHW'({s, 1'b0}) + CHW'(2);
	endfunction

	// Control state
	logic [2:0]                  state_q, state_d;
	logic [CW-1:0]               cnt_q, cnt_d;
	logic [mhpq_pkg::CAP_W-1:0]  cap_q;
	logic                        del_q, del_d;      // delete that has not climbed: may sink
	logic [1:0]                  stat_q, stat_d;
	logic                        res_valid_q;

	// Payload state
	logic [KEY_WIDTH-1:0]        key_q, key_d;      // key moving through the heap
	logic [AW-1:0]               slot_q, slot_d;    // hole the moving key sits over
	logic [KEY_WIDTH-1:0]        lkey_q, lkey_d;    // left child held while right is read
	logic [KEY_WIDTH-1:0]        top_q;             // copy of slot 0
	logic [1:0]                  res_status_q;
	logic                        res_top_valid_q;
	logic [KEY_WIDTH-1:0]        res_top_key_q;
	logic [CW-1:0]               res_count_q;

	// RAM port
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [KEY_WIDTH-1:0]        ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [KEY_WIDTH-1:0]        ram_rdata;

	logic                        in_acc;
	logic                        res_load;
	logic                        full;
	logic [CW-1:0]               pos_ext;
	logic [CW-1:0]               cnt_dec;
	logic [AW-1:0]               par;
	logic [CHW-1:0]              left_c;
	logic [CHW-1:0]              right_c;
	logic [CHW-1:0]              cnt_ch;
	logic                        pick_r;
	logic [KEY_WIDTH-1:0]        pick_key;
	logic [AW-1:0]               pick_slot;
	logic [CHW-1:0]              pick_left;
	logic                        cfg_wr;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// A push is refused once the count reaches the capacity or the RAM depth
	assign full = (CMPW'(cnt_q) >= CMPW'(cap_q)) || (cnt_q >= CW'(DEPTH));

	assign pos_ext   = CW'(position);
	assign cnt_dec   = cnt_q - CW'(1);
	assign par       = parent_of(slot_q);
	assign left_c    = left_of(slot_q);
	assign right_c   = right_of(slot_q);
	assign cnt_ch    = CHW'(cnt_q);

	// Smaller child; the left one wins a tie
	assign pick_r    = key_lt(ram_rdata, lkey_q);
	assign pick_key  = pick_r ? ram_rdata : lkey_q;
	assign pick_slot = pick_r ? right_c[AW-1:0] : left_c[AW-1:0];
	assign pick_left = left_of(pick_slot);

	assign res_load  = (state_q == S_DONE) && (!res_valid_q || !out_stall);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		del_d     = del_q;
		stat_d    = stat_q;
		key_d     = key_q;
		slot_d    = slot_q;
		lkey_d    = lkey_q;
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = key_q;
		ram_raddr = par;

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					stat_d = mhpq_pkg::ST_OK;
					if (cmd == mhpq_pkg::CMD_PUSH) begin
						if (full) begin
							stat_d  = mhpq_pkg::ST_FULL;
							state_d = S_DONE;
						end else begin
							key_d  = key_in;
							slot_d = cnt_q[AW-1:0];
							cnt_d  = cnt_q + CW'(1);
							del_d  = 1'b0;
							if (cnt_q == '0) begin
								// first entry lands straight at the root
								ram_we    = 1'b1;
								ram_waddr = '0;
								ram_wdata = key_in;
								state_d   = S_DONE;
							end else begin
								ram_raddr = parent_of(cnt_q[AW-1:0]);
								state_d   = S_UP;
							end
						end
					end else begin
						if (cnt_q == '0) begin
							stat_d  = mhpq_pkg::ST_EMPTY;
							state_d = S_DONE;
						end else if (pos_ext >= cnt_q) begin
							stat_d  = mhpq_pkg::ST_RANGE;
							state_d = S_DONE;
						end else begin
							cnt_d  = cnt_dec;
							slot_d = position;
							del_d  = 1'b1;
							if (pos_ext == cnt_dec) begin
								state_d = S_DONE;
							end else begin
								// fetch the last entry to fill the hole
								ram_raddr = cnt_dec[AW-1:0];
								state_d   = S_LAST;
							end
						end
					end
				end
			end

			S_LAST: begin
				key_d = ram_rdata;
				if (slot_q != '0) begin
					ram_raddr = par;
					state_d   = S_UP;
				end else if (left_c < cnt_ch) begin
					ram_raddr = left_c[AW-1:0];
					state_d   = S_DNL;
				end else begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					state_d   = S_DONE;
				end
			end

			S_UP: begin
				if (key_lt(key_q, ram_rdata)) begin
					// parent moves down into the hole
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					slot_d    = par;
					del_d     = 1'b0;
					ram_raddr = parent_of(par);
					state_d   = (par == '0) ? S_FIN : S_UP;
				end else if (del_q && (left_c < cnt_ch)) begin
					ram_raddr = left_c[AW-1:0];
					state_d   = S_DNL;
				end else begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end
			end

			S_DNL: begin
				lkey_d = ram_rdata;
				if (right_c < cnt_ch) begin
					ram_raddr = right_c[AW-1:0];
					state_d   = S_DNR;
				end else if (key_lt(ram_rdata, key_q)) begin
					// lone left child is the last entry: it has no children
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					slot_d    = left_c[AW-1:0];
					state_d   = S_FIN;
				end else begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end
			end

			S_DNR: begin
				if (key_lt(pick_key, key_q)) begin
					ram_we    = 1'b1;
					ram_wdata = pick_key;
					slot_d    = pick_slot;
					ram_raddr = pick_left[AW-1:0];
					state_d   = (pick_left < cnt_ch) ? S_DNL : S_FIN;
				end else begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end
			end

			S_FIN: begin
				ram_we  = 1'b1;
				state_d = S_DONE;
			end

			S_DONE: begin
				if (res_load) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Heap store. No two accesses of one request touch the same slot at once,
	// so read-during-write needs no forwarding.
	mhpq_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (DEPTH)
	) u_heap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			del_q       <= 1'b0;
			stat_q      <= mhpq_pkg::ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			del_q   <= del_d;
			stat_q  <= stat_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		key_q  <= key_d;
		slot_q <= slot_d;
		lkey_q <= lkey_d;
		// keep a copy of the root so the minimum never costs a RAM read
		if (ram_we && (ram_waddr == '0)) begin
			top_q <= ram_wdata;
		end
		if (res_load) begin
			res_status_q    <= stat_q;
			res_top_valid_q <= (cnt_q != '0);
			res_top_key_q   <= (cnt_q != '0) ? top_q : '0;
			res_count_q     <= cnt_q;
		end
	end

	assign out_valid = res_valid_q;
	assign status    = res_status_q;
	assign top_valid = res_top_valid_q;
	assign top_key   = res_top_key_q;
	assign count     = res_count_q;

	// Configuration: one register, capacity_limit; other indexes read as zero
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[mhpq_pkg::PADDR_W-1] == mhpq_pkg::REG_IDX_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= mhpq_pkg::CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[mhpq_pkg::CAP_W-1:0];
		end
	end

	assign prdata = (paddr[mhpq_pkg::PADDR_W-1] == mhpq_pkg::REG_IDX_CAPACITY)
		? mhpq_pkg::PDATA_W'(cap_q) : '0;

endmodule

/* sv/mhpq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mhpq_ram #(
	parameter int WIDTH = mhpq_pkg::KEY_WIDTH_DEF,
	parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/mhpq_checker.sv */
// Port-level assertions for the min-heap priority queue, bound to its top level.
`include "min_heap_priority_queue_macros.svh"

module mhpq_checker #(
	parameter int DEPTH     = mhpq_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   status,
	input logic                         top_valid,
	input logic signed [KEY_WIDTH-1:0]  top_key,
	input logic [$clog2(DEPTH+1)-1:0]   count,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [mhpq_pkg::PADDR_W-1:0] paddr,
	input logic [mhpq_pkg::PDATA_W-1:0] pwdata,
	input logic [mhpq_pkg::PDATA_W-1:0] prdata,
	input logic                         pready
);

	`MHPQ_ASSERT_NEXT(a_result_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(top_key) && $stable(count) && $stable(top_valid), "stalled result changed")

	`MHPQ_ASSERT_NOW(a_top_matches_count, out_valid, (top_valid == (count != '0)) && (top_valid || (top_key == '0)), "top fields disagree with count")

	`MHPQ_ASSERT_NOW(a_empty_status, out_valid && (status == mhpq_pkg::ST_EMPTY), count == '0, "empty status with nonzero count")

	`MHPQ_ASSERT_NEXT(a_one_request, in_valid && !in_stall, in_stall, "second request taken while one is in work")

	`MHPQ_ASSERT_NEXT(a_cap_readback, psel && penable && pwrite && pready && (paddr[mhpq_pkg::PADDR_W-1] == mhpq_pkg::REG_IDX_CAPACITY), (paddr[mhpq_pkg::PADDR_W-1] != mhpq_pkg::REG_IDX_CAPACITY) || ((prdata[mhpq_pkg::CAP_W-1:0] == $past(pwdata[mhpq_pkg::CAP_W-1:0])) && (prdata[mhpq_pkg::PDATA_W-1:mhpq_pkg::CAP_W] == '0)), "capacity readback mismatch")

endmodule

bind min_heap_priority_queue mhpq_checker #(
	.DEPTH     (DEPTH),
	.KEY_WIDTH (KEY_WIDTH)
) u_mhpq_checker (.*);

/* tb/sv/min_heap_priority_queue_tb.sv */
// Self-checking testbench of the min-heap priority queue: random and directed requests.
module min_heap_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = mhpq_pkg::DEPTH_DEF;
	localparam int KEY_W = mhpq_pkg::KEY_WIDTH_DEF;
	localparam int POS_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CFG_PAD_W = mhpq_pkg::PDATA_W - mhpq_pkg::CAP_W;

	// Byte addresses on the configuration port; the spare one decodes to no register
	localparam logic [mhpq_pkg::PADDR_W-1:0] ADDR_CAPACITY = {mhpq_pkg::REG_IDX_CAPACITY, 2'b00};
	localparam logic [mhpq_pkg::PADDR_W-1:0] ADDR_SPARE    = 3'd4;

	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int QUIET_LIMIT   = 5000;  // watchdog: cycles with no handshake at all

	typedef logic signed [KEY_W-1:0] heap_key_t;

	typedef struct packed {
		logic             cmd;
		heap_key_t        key;
		logic [POS_W-1:0] pos;
	} heap_request_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             top_valid;
		heap_key_t        top_key;
		logic [CNT_W-1:0] count;
	} heap_result_t;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// Request channel
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             cmd = mhpq_pkg::CMD_PUSH;
	heap_key_t        key_in = '0;
	logic [POS_W-1:0] position = '0;

	// Result channel
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       status;
	logic             top_valid;
	heap_key_t        top_key;
	logic [CNT_W-1:0] count;

	// Configuration port
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [mhpq_pkg::PADDR_W-1:0] paddr = '0;
	logic [mhpq_pkg::PDATA_W-1:0] pwdata = '0;
	logic [mhpq_pkg::PDATA_W-1:0] prdata;
	logic                         pready;

	min_heap_priority_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.key_in    (key_in),
		.position  (position),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.top_valid (top_valid),
		.top_key   (top_key),
		.count     (count),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// ------------------------------------------------------------------
	// Shadow heap: our own view of the block's state and its register
	// ------------------------------------------------------------------
	heap_key_t                  heap_keys [DEPTH];
	int                         heap_size = 0;
	logic [mhpq_pkg::CAP_W-1:0] cap_shadow = mhpq_pkg::CAP_RESET;

	heap_request_t request_q [$];        // requests waiting to be offered
	heap_result_t  expected_results [$]; // results owed by the block, oldest first

	int fail_count = 0;
	int requests_accepted = 0;
	int results_checked = 0;
	int push_total = 0;
	int delete_total = 0;
	int cap_settings = 0;
	int status_seen [4] = '{default: 0};

	// Idle shares in percent, switched per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// Long receiver hold-off: the stimulus bumps hold_requests, the result side serves it
	int hold_requests = 0;

	// Move a key toward the root while it beats its parent
	function automatic void heap_rise(int slot);
		int parent;
		heap_key_t tmp;
		while (slot > 0) begin
			parent = (slot - 1) / 2;
			if (!(heap_keys[slot] < heap_keys[parent]))
				break;
			tmp = heap_keys[slot];
			heap_keys[slot] = heap_keys[parent];
			heap_keys[parent] = tmp;
			slot = parent;
		end
	endfunction

	// Push a key down, always swapping with the smaller child, while that child is strictly smaller
	function automatic void heap_sink(int slot);
		int left;
		int right;
		int pick;
		heap_key_t tmp;
		while (slot < heap_size) begin
			left = 2 * slot + 1;
			right = left + 1;
			if (left >= heap_size)
				break;
			pick = left;
			if (right < heap_size && heap_keys[right] < heap_keys[left])
				pick = right;
			if (!(heap_keys[pick] < heap_keys[slot]))
				break;
			tmp = heap_keys[slot];
			heap_keys[slot] = heap_keys[pick];
			heap_keys[pick] = tmp;
			slot = pick;
		end
	endfunction

	function automatic int cap_effective();
		return (cap_shadow > DEPTH) ? DEPTH : int'(cap_shadow);
	endfunction

	// Apply one request to the shadow heap and return the result the block owes
	function automatic heap_result_t heap_apply(heap_request_t req);
		heap_result_t res;
		int slot;
		slot = int'(req.pos);
		res.status = mhpq_pkg::ST_OK;
		if (req.cmd == mhpq_pkg::CMD_PUSH) begin
			if (heap_size >= cap_effective()) begin
				res.status = mhpq_pkg::ST_FULL;
			end else begin
				heap_keys[heap_size] = req.key;
				heap_size++;
				heap_rise(heap_size - 1);
			end
		end else if (heap_size == 0) begin
			res.status = mhpq_pkg::ST_EMPTY;
		end else if (slot >= heap_size) begin
			res.status = mhpq_pkg::ST_RANGE;
		end else begin
			// Last entry fills the hole, then repair in whichever direction it needs
			heap_size--;
			heap_keys[slot] = heap_keys[heap_size];
			if (slot < heap_size) begin
				heap_rise(slot);
				heap_sink(slot);
			end
		end
		res.top_valid = (heap_size > 0);
		res.top_key = (heap_size > 0) ? heap_keys[0] : '0;
		res.count = CNT_W'(heap_size);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request driver: offer queued requests, hold while stalled
	// ------------------------------------------------------------------
	heap_request_t offered;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// Record the accepted request before a new one replaces it
			if (in_valid && !in_stall) begin
				expected_results.push_back(heap_apply(offered));
				requests_accepted++;
				if (offered.cmd == mhpq_pkg::CMD_PUSH)
					push_total++;
				else
					delete_total++;
			end
			// Hold a stalled request; otherwise offer the next one or idle
			if (!in_valid || !in_stall) begin
				if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = request_q.pop_front();
					in_valid <= 1'b1;
					cmd <= offered.cmd;
					key_in <= offered.key;
					position <= offered.pos;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare against the oldest expectation, drive stall
	// ------------------------------------------------------------------
	int hold_served = 0;
	int hold_left = 0;
	heap_result_t owed;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: status %0d count %0d",
						status, count);
					fail_count++;
				end else begin
					owed = expected_results.pop_front();
					results_checked++;
					status_seen[owed.status]++;
					if (status !== owed.status) begin
						$error("status: expected %0d, got %0d", owed.status, status);
						fail_count++;
					end
					if (top_valid !== owed.top_valid) begin
						$error("top_valid: expected %0d, got %0d", owed.top_valid, top_valid);
						fail_count++;
					end
					if (top_key !== owed.top_key) begin
						$error("top_key: expected %0d, got %0d", owed.top_key, top_key);
						fail_count++;
					end
					if (count !== owed.count) begin
						$error("count: expected %0d, got %0d", owed.count, count);
						fail_count++;
					end
				end
			end
			// Start a long hold-off when asked, else stall at random
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if no handshake happens for too long
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	int plan_size = 0; // entry count the queued requests will leave behind

	// Queue a request and advance the planned count, which needs no keys
	task automatic queue_request(logic op, heap_key_t key, int pos);
		heap_request_t req;
		req.cmd = op;
		req.key = key;
		req.pos = POS_W'(pos);
		request_q.push_back(req);
		if (op == mhpq_pkg::CMD_PUSH) begin
			if (plan_size < cap_effective())
				plan_size++;
		end else if (plan_size > 0 && pos < plan_size) begin
			plan_size--;
		end
	endtask

	function automatic heap_key_t pick_key();
		heap_key_t k;
		case ($urandom_range(3))
			0: k = heap_key_t'($urandom);
			1: k = heap_key_t'($urandom_range(16)) - 8;  // narrow band, many ties
			2: begin
				case ($urandom_range(3))
					0: k = {1'b0, {(KEY_W-1){1'b1}}};
					1: k = {1'b1, {(KEY_W-1){1'b0}}};
					2: k = '0;
					default: k = '1;
				endcase
			end
			default: k = heap_key_t'($urandom_range(2000)) - 1000;
		endcase
		return k;
	endfunction

	// Mostly pushes and in-range deletes; the rest are deletes past the end or on empty
	task automatic queue_random(int n, int push_pct);
		int r;
		int pos;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < push_pct) begin
				queue_request(mhpq_pkg::CMD_PUSH, pick_key(), $urandom_range(DEPTH - 1));
			end else if (r < push_pct + 6 && plan_size < DEPTH) begin
				queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom),
					$urandom_range(DEPTH - 1, plan_size));
			end else begin
				if (plan_size == 0)
					pos = $urandom_range(DEPTH - 1);
				else begin
					case ($urandom_range(3))
						0: pos = 0;
						1: pos = plan_size - 1;
						default: pos = $urandom_range(plan_size - 1);
					endcase
				end
				queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), pos);
			end
		end
	endtask

	// Wait until every queued request is sent and every owed result has come back, then let the block settle
	task automatic drain();
		while (request_q.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [mhpq_pkg::PADDR_W-1:0] addr,
		logic [mhpq_pkg::PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_CAPACITY)
			cap_shadow = data[mhpq_pkg::CAP_W-1:0];
	endtask

	task automatic check_capacity_readback();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_CAPACITY;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata[mhpq_pkg::CAP_W-1:0] !== cap_shadow) begin
			$error("capacity_limit: expected %0d, got %0d", cap_shadow,
				prdata[mhpq_pkg::CAP_W-1:0]);
			fail_count++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// One phase: settle, write the spare address and the capacity, read the capacity back, then run random requests
	task automatic run_phase(int cap, int snd_pct, int rcv_pct, int n, int push_pct,
		bit long_hold);
		drain();
		apb_write(ADDR_SPARE, $urandom);
		apb_write(ADDR_CAPACITY, {CFG_PAD_W'($urandom), mhpq_pkg::CAP_W'(cap)});
		check_capacity_readback();
		cap_settings++;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		queue_random(n, push_pct);
		if (long_hold)
			hold_requests++;
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Capacity comes out of reset at its full value
		check_capacity_readback();

		// Directed requests at the reset capacity
		send_idle_pct = 12;
		recv_idle_pct = 56;
		queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), 0);  // delete on empty
		queue_request(mhpq_pkg::CMD_DELETE, {1'b0, {(KEY_W-1){1'b1}}}, DEPTH - 1);
		queue_request(mhpq_pkg::CMD_PUSH, {1'b0, {(KEY_W-1){1'b1}}}, DEPTH - 1);  // largest
		queue_request(mhpq_pkg::CMD_PUSH, {1'b1, {(KEY_W-1){1'b0}}}, 0);          // smallest
		queue_request(mhpq_pkg::CMD_PUSH, '0, 21);
		queue_request(mhpq_pkg::CMD_PUSH, '1, 42);
		queue_request(mhpq_pkg::CMD_PUSH, 1, 0);
		queue_request(mhpq_pkg::CMD_PUSH, {1'b1, {(KEY_W-1){1'b0}}}, 5);  // duplicate minimum
		queue_request(mhpq_pkg::CMD_PUSH, 5, DEPTH - 1);
		queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), DEPTH - 1);  // far beyond
		queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), 7);    // exactly at count
		queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), 6);    // last slot
		queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), 0);    // root
		queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), 2);    // middle
		queue_request(mhpq_pkg::CMD_PUSH, -100, 3);
		queue_request(mhpq_pkg::CMD_PUSH, {1'b0, {(KEY_W-1){1'b1}}}, 9);
		queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), 1);
		repeat (5) queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), 0); // empty it
		queue_request(mhpq_pkg::CMD_DELETE, heap_key_t'($urandom), 3);    // empty again

		// Random phases: capacity, sender idle %, receiver idle %, requests, push %, long hold
		run_phase(DEPTH,     12, 56, 300, 60, 1'b0);
		run_phase(127,       12, 56, 250, 80, 1'b0);  // saturates at DEPTH, reach full
		run_phase(3,         56, 12, 200, 45, 1'b0);  // capacity below the count
		run_phase(0,         56, 12, 150, 50, 1'b0);  // every push full
		run_phase(1,         56, 12, 150, 50, 1'b0);
		run_phase(DEPTH,      0,  0, 350, 60, 1'b1);
		run_phase(40,         0,  0, 250, 55, 1'b0);
		run_phase(DEPTH,      0,  0, 180, 40, 1'b1);

		drain();

		$display("covered %0d requests (%0d push, %0d delete) over %0d capacity settings",
			requests_accepted, push_total, delete_total, cap_settings);
		$display("statuses seen: ok %0d, full %0d, empty %0d, past end %0d",
			status_seen[mhpq_pkg::ST_OK], status_seen[mhpq_pkg::ST_FULL],
			status_seen[mhpq_pkg::ST_EMPTY], status_seen[mhpq_pkg::ST_RANGE]);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
